// File: rtl/core/sqtc_pkg.sv
// ----------------------------------------------------------------------------
// sqtc_pkg
// Shared widths, types and the corner cut table of the square thumbnail
// crop scaler.
// ----------------------------------------------------------------------------
package sqtc_pkg;

    // Field widths
    localparam int ColW     = 7;
    localparam int DimW     = 16;
    localparam int AddrW    = 32;
    localparam int ScrW     = 12;
    localparam int SizeW    = 8;
    localparam int CutW     = 3;
    localparam int ProdW    = ColW + DimW;
    localparam int QuotW    = DimW;

    // Reciprocal scaling: exact floor division of a ProdW-bit value by
    // an 8-bit size needs ProdW + 8 fractional bits
    localparam int RecipShift = ProdW + SizeW;
    localparam int RecipW     = RecipShift + 1;
    localparam int MulW       = ProdW + RecipW;

    // Stream and register port widths
    localparam int InTdataW  = 16;
    localparam int OutTdataW = 64;
    localparam int PaddrW    = 5;
    localparam int PdataW    = 32;

    // Defaults
    localparam int MaxTileDefault = 128;
    localparam int CutRows        = 10;
    localparam logic [SizeW-1:0] TileSizeReset = 8'd88;
    localparam logic [AddrW-1:0] PixelOffset   = 32'd8;

    // Register indexes, one word apart on the APB port
    typedef enum logic [2:0] {
        REG_IMAGE_BASE,
        REG_SRC_WIDTH,
        REG_SRC_HEIGHT,
        REG_TILE_EDGE,
        REG_DEST_LEFT,
        REG_DEST_TOP
    } t_reg_idx;

    typedef struct packed {
        logic [AddrW-1:0] image_base;
        logic [DimW-1:0]  src_width;
        logic [DimW-1:0]  src_height;
        logic [SizeW-1:0] tile_edge;
        logic [ScrW-1:0]  dest_left;
        logic [ScrW-1:0]  dest_top;
    } t_cfg;

    // After the tile mask stage
    typedef struct packed {
        logic              drawn;
        logic [ProdW-1:0]  row_prod;
        logic [ProdW-1:0]  col_prod;
        logic [RecipW-1:0] recip;
        logic [DimW-1:0]   sx0;
        logic [DimW-1:0]   sy0;
        logic [ScrW-1:0]   screen_x;
        logic [ScrW-1:0]   screen_y;
    } t_mask;

    // After the scale stages: clamped source coordinates
    typedef struct packed {
        logic            drawn;
        logic [DimW-1:0] sx;
        logic [DimW-1:0] sy;
        logic [ScrW-1:0] screen_x;
        logic [ScrW-1:0] screen_y;
    } t_coord;

    // Result item
    typedef struct packed {
        logic             drawn;
        logic [AddrW-1:0] src_address;
        logic [ScrW-1:0]  screen_x;
        logic [ScrW-1:0]  screen_y;
    } t_res;

    // Corner cut for the first ten rows counted from the nearer edge
    function automatic logic [CutW-1:0] corner_trim(input logic [3:0] idx);
        logic [CutW-1:0] cut;
        case (idx)
            4'd0:    cut = 3'd6;
            4'd1:    cut = 3'd4;
            4'd2:    cut = 3'd3;
            4'd3:    cut = 3'd2;
            4'd4:    cut = 3'd1;
            4'd5:    cut = 3'd1;
            default: cut = 3'd0;
        endcase
        return cut;
    endfunction

endpackage

// File: rtl/core/sqtc_cfg.sv
// ----------------------------------------------------------------------------
// sqtc_cfg
// Register bank behind the APB-style port: image base, source size,
// tile size and screen placement.
// ----------------------------------------------------------------------------
module sqtc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sqtc_pkg::PaddrW-1:0] paddr,
    input  logic [sqtc_pkg::PdataW-1:0] pwdata,
    output logic [sqtc_pkg::PdataW-1:0] prdata,
    output logic                        pready,
    output sqtc_pkg::t_cfg              o_cfg
);
    import sqtc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write the addressed register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_base <= '0;
            r_cfg.src_width  <= '0;
            r_cfg.src_height <= '0;
            r_cfg.tile_edge  <= TileSizeReset;
            r_cfg.dest_left  <= '0;
            r_cfg.dest_top   <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_IMAGE_BASE: r_cfg.image_base <= pwdata;
                REG_SRC_WIDTH:  r_cfg.src_width  <= pwdata[DimW-1:0];
                REG_SRC_HEIGHT: r_cfg.src_height <= pwdata[DimW-1:0];
                REG_TILE_EDGE:  r_cfg.tile_edge  <= pwdata[SizeW-1:0];
                REG_DEST_LEFT:  r_cfg.dest_left  <= pwdata[ScrW-1:0];
                REG_DEST_TOP:   r_cfg.dest_top   <= pwdata[ScrW-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            REG_IMAGE_BASE: prdata = r_cfg.image_base;
            REG_SRC_WIDTH:  prdata = PdataW'(r_cfg.src_width);
            REG_SRC_HEIGHT: prdata = PdataW'(r_cfg.src_height);
            REG_TILE_EDGE:  prdata = PdataW'(r_cfg.tile_edge);
            REG_DEST_LEFT:  prdata = PdataW'(r_cfg.dest_left);
            REG_DEST_TOP:   prdata = PdataW'(r_cfg.dest_top);
            default:        prdata = '0;
        endcase
    end

    a_tile_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && w_idx == REG_TILE_EDGE) |=> r_cfg.tile_edge == $past(pwdata[SizeW-1:0]))
        else $error("tile size register did not take the written value");

endmodule

// File: rtl/core/sqtc_mask.sv
// ----------------------------------------------------------------------------
// sqtc_mask
// First pipeline stage: tile size, square crop, rounded corner mask,
// screen position and the crop products for the scaler.
// ----------------------------------------------------------------------------
module sqtc_mask #(
    parameter int MaxTile = sqtc_pkg::MaxTileDefault
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sqtc_pkg::t_cfg             i_cfg,
    input  logic                       i_vld,
    output logic                       o_rdy,
    input  logic [sqtc_pkg::ColW-1:0]  i_col,
    input  logic [sqtc_pkg::ColW-1:0]  i_row,
    output logic                       o_vld,
    input  logic                       i_rdy,
    output sqtc_pkg::t_mask            o_data
);
    import sqtc_pkg::*;

    localparam int IdxW = $clog2(MaxTile + 1);
    localparam logic [SizeW-1:0] MaxSize = SizeW'(MaxTile);

    logic [RecipW-1:0] w_recip_tab [0:MaxTile];

    // Reciprocal of each tile size, worked out at elaboration
    for (genvar s = 0; s <= MaxTile; s++) begin : g_recip
        if (s == 0) begin : g_zero
            assign w_recip_tab[s] = '0;
        end else begin : g_div
            localparam logic [63:0] RecipFull =
                ((64'd1 << RecipShift) + 64'(s) - 64'd1) / 64'(s);
            assign w_recip_tab[s] = RecipFull[RecipW-1:0];
        end
    end

    logic             r_vld;
    t_mask            r_data;
    t_mask            n_data;
    logic [SizeW-1:0] w_size;
    logic [SizeW-1:0] w_col;
    logic [SizeW-1:0] w_row;
    logic [SizeW-1:0] w_cut;
    logic [SizeW-1:0] w_mirror;
    logic [DimW-1:0]  w_crop;
    logic             w_ready;

    assign w_size = (i_cfg.tile_edge > MaxSize) ? MaxSize : i_cfg.tile_edge;
    assign w_col  = SizeW'(i_col);
    assign w_row  = SizeW'(i_row);

    // Corner cut: top rows first, then rows mirrored from the bottom edge
    assign w_mirror = w_size - 8'd1 - w_row;
    always_comb begin
        if (w_row < SizeW'(CutRows)) begin
            w_cut = SizeW'(corner_trim(w_row[3:0]));
        end else if ((9'(w_row) + 9'(CutRows) >= 9'(w_size)) && (w_row < w_size)) begin
            w_cut = SizeW'(corner_trim(w_mirror[3:0]));
        end else begin
            w_cut = '0;
        end
    end

    // Crop to a square, trimming the longer side equally
    always_comb begin
        n_data = '0;
        w_crop = i_cfg.src_width;
        if (i_cfg.src_width > i_cfg.src_height) begin
            w_crop     = i_cfg.src_height;
            n_data.sx0 = (i_cfg.src_width - i_cfg.src_height) >> 1;
        end else if (i_cfg.src_height > i_cfg.src_width) begin
            n_data.sy0 = (i_cfg.src_height - i_cfg.src_width) >> 1;
        end
        n_data.drawn = (i_cfg.src_width != '0) && (i_cfg.src_height != '0)
                    && (w_size != '0) && (w_col < w_size) && (w_row < w_size)
                    && (9'({w_cut, 1'b0}) < 9'(w_size))
                    && (w_col >= w_cut) && (w_col < w_size - w_cut);
        n_data.row_prod = ProdW'(i_row) * ProdW'(w_crop);
        n_data.col_prod = ProdW'(i_col) * ProdW'(w_crop);
        n_data.recip    = w_recip_tab[w_size[IdxW-1:0]];
        n_data.screen_x = i_cfg.dest_left + ScrW'(i_col);
        n_data.screen_y = i_cfg.dest_top + ScrW'(i_row);
    end

    // Advance when the stage is empty or its content moves on
    assign w_ready = ~r_vld | i_rdy;
    assign o_rdy   = w_ready;
    assign o_vld   = r_vld;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_ready) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_vld) begin
            r_data <= n_data;
        end
    end

endmodule

// File: rtl/core/sqtc_scale.sv
// ----------------------------------------------------------------------------
// sqtc_scale
// Two pipeline stages: nearest-neighbour scaling by reciprocal
// multiplication, then crop offset and clamp to the image edge.
// ----------------------------------------------------------------------------
module sqtc_scale (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sqtc_pkg::t_cfg   i_cfg,
    input  logic             i_vld,
    output logic             o_rdy,
    input  sqtc_pkg::t_mask  i_data,
    output logic             o_vld,
    input  logic             i_rdy,
    output sqtc_pkg::t_coord o_data
);
    import sqtc_pkg::*;

    // Stage A: quotients
    logic             r_vld_a;
    logic             r_drawn_a;
    logic [QuotW-1:0] r_qrow_a;
    logic [QuotW-1:0] r_qcol_a;
    logic [DimW-1:0]  r_sx0_a;
    logic [DimW-1:0]  r_sy0_a;
    logic [ScrW-1:0]  r_scrx_a;
    logic [ScrW-1:0]  r_scry_a;
    logic [MulW-1:0]  w_mul_row;
    logic [MulW-1:0]  w_mul_col;

    // Stage B: clamped coordinates
    logic             r_vld_b;
    t_coord           r_data_b;
    t_coord           n_data_b;
    logic [DimW:0]    w_sum_x;
    logic [DimW:0]    w_sum_y;

    logic             w_ready_a;
    logic             w_ready_b;

    assign w_ready_b = ~r_vld_b | i_rdy;
    assign w_ready_a = ~r_vld_a | w_ready_b;
    assign o_rdy     = w_ready_a;
    assign o_vld     = r_vld_b;
    assign o_data    = r_data_b;

    // Divide by the tile size through its reciprocal
    assign w_mul_row = MulW'(i_data.row_prod) * MulW'(i_data.recip);
    assign w_mul_col = MulW'(i_data.col_prod) * MulW'(i_data.recip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (w_ready_a) begin
                r_vld_a <= i_vld;
            end
            if (w_ready_b) begin
                r_vld_b <= r_vld_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_vld) begin
            r_drawn_a <= i_data.drawn;
            r_qrow_a  <= w_mul_row[RecipShift +: QuotW];
            r_qcol_a  <= w_mul_col[RecipShift +: QuotW];
            r_sx0_a   <= i_data.sx0;
            r_sy0_a   <= i_data.sy0;
            r_scrx_a  <= i_data.screen_x;
            r_scry_a  <= i_data.screen_y;
        end
    end

    // Add the crop offset and hold the coordinate inside the image
    assign w_sum_x = (DimW+1)'(r_sx0_a) + (DimW+1)'(r_qcol_a);
    assign w_sum_y = (DimW+1)'(r_sy0_a) + (DimW+1)'(r_qrow_a);

    always_comb begin
        n_data_b.drawn    = r_drawn_a;
        n_data_b.screen_x = r_scrx_a;
        n_data_b.screen_y = r_scry_a;
        if (w_sum_x >= (DimW+1)'(i_cfg.src_width)) begin
            n_data_b.sx = i_cfg.src_width - 16'd1;
        end else begin
            n_data_b.sx = w_sum_x[DimW-1:0];
        end
        if (w_sum_y >= (DimW+1)'(i_cfg.src_height)) begin
            n_data_b.sy = i_cfg.src_height - 16'd1;
        end else begin
            n_data_b.sy = w_sum_y[DimW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_b && r_vld_a) begin
            r_data_b <= n_data_b;
        end
    end

    a_stall_keeps_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_b && !i_rdy) |=> (r_vld_b && $stable(r_data_b)))
        else $error("stalled scale stage lost or changed its item");

    a_full_a_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_a && r_vld_b && !i_rdy) |-> !o_rdy)
        else $error("scale stages full but input still ready");

endmodule

// File: rtl/core/sqtc_addr.sv
// ----------------------------------------------------------------------------
// sqtc_addr
// Two pipeline stages: row-major pixel index, then byte address; the
// second stage is the output register.
// ----------------------------------------------------------------------------
module sqtc_addr (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sqtc_pkg::t_cfg   i_cfg,
    input  logic             i_vld,
    output logic             o_rdy,
    input  sqtc_pkg::t_coord i_data,
    output logic             o_vld,
    input  logic             i_rdy,
    output sqtc_pkg::t_res   o_data
);
    import sqtc_pkg::*;

    // Stage C: row offset
    logic             r_vld_c;
    logic             r_drawn_c;
    logic [AddrW-1:0] r_rowoff_c;
    logic [DimW-1:0]  r_sx_c;
    logic [ScrW-1:0]  r_scrx_c;
    logic [ScrW-1:0]  r_scry_c;

    // Stage D: result
    logic             r_vld_d;
    t_res             r_data_d;
    logic [AddrW-1:0] w_index;

    logic             w_ready_c;
    logic             w_ready_d;

    assign w_ready_d = ~r_vld_d | i_rdy;
    assign w_ready_c = ~r_vld_c | w_ready_d;
    assign o_rdy     = w_ready_c;
    assign o_vld     = r_vld_d;
    assign o_data    = r_data_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else begin
            if (w_ready_c) begin
                r_vld_c <= i_vld;
            end
            if (w_ready_d) begin
                r_vld_d <= r_vld_c;
            end
        end
    end

    // Source row times image width
    always_ff @(posedge i_clk) begin
        if (w_ready_c && i_vld) begin
            r_drawn_c  <= i_data.drawn;
            r_rowoff_c <= AddrW'(i_data.sy) * AddrW'(i_cfg.src_width);
            r_sx_c     <= i_data.sx;
            r_scrx_c   <= i_data.screen_x;
            r_scry_c   <= i_data.screen_y;
        end
    end

    // Byte address of the pixel; zero when not drawn
    assign w_index = r_rowoff_c + AddrW'(r_sx_c);

    always_ff @(posedge i_clk) begin
        if (w_ready_d && r_vld_c) begin
            r_data_d.drawn       <= r_drawn_c;
            r_data_d.src_address <= r_drawn_c
                ? (i_cfg.image_base + PixelOffset + {w_index[AddrW-3:0], 2'b00})
                : '0;
            r_data_d.screen_x    <= r_scrx_c;
            r_data_d.screen_y    <= r_scry_c;
        end
    end

    a_blank_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_d && !r_data_d.drawn) |-> r_data_d.src_address == '0)
        else $error("address not cleared for an undrawn pixel");

endmodule

// File: rtl/core/square_thumbnail_crop_scaler_unit.sv
// ----------------------------------------------------------------------------
// square_thumbnail_crop_scaler_unit
// Per-pixel address generator for a centre-cropped, nearest-neighbour
// scaled thumbnail with rounded corners.
//
//   channel   direction  handshake              payload
//   s_axis    in         tvalid / tready        out_col, out_row
//   m_axis    out        tvalid / tready        drawn, src_address, screen_x/y
//   apb       in         psel, penable, pready  six registers at 4*i
//
// One transfer is taken every cycle unless the result side stalls; each
// result passes through the five register stages (mask, scale, clamp,
// row offset, address). Each stage has its own valid bit and
// ready, so bubbles close up under a stall and nothing is lost or repeated.
// Reset is synchronous and empties the pipeline; tile size resets to 88.
// ----------------------------------------------------------------------------
module square_thumbnail_crop_scaler_unit #(
    parameter int MaxTile = sqtc_pkg::MaxTileDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tdata: out_col[6:0], out_row[13:7], zero[15:14]
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [sqtc_pkg::InTdataW-1:0]  s_axis_tdata,
    // tdata: drawn[0], src_address[32:1], screen_x[44:33], screen_y[56:45],
    //        zero[63:57]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [sqtc_pkg::OutTdataW-1:0] m_axis_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sqtc_pkg::PaddrW-1:0]    paddr,
    input  logic [sqtc_pkg::PdataW-1:0]    pwdata,
    output logic [sqtc_pkg::PdataW-1:0]    prdata,
    output logic                           pready
);
    import sqtc_pkg::*;

    t_cfg   w_cfg;
    t_mask  w_mask;
    t_coord w_coord;
    t_res   w_res;
    logic   w_mask_vld;
    logic   w_mask_rdy;
    logic   w_coord_vld;
    logic   w_coord_rdy;

    // Registers
    sqtc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Tile mask and crop products
    sqtc_mask #(
        .MaxTile (MaxTile)
    ) u_mask (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_vld   (s_axis_tvalid),
        .o_rdy   (s_axis_tready),
        .i_col   (s_axis_tdata[ColW-1:0]),
        .i_row   (s_axis_tdata[2*ColW-1:ColW]),
        .o_vld   (w_mask_vld),
        .i_rdy   (w_mask_rdy),
        .o_data  (w_mask)
    );

    // Scale and clamp
    sqtc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_vld   (w_mask_vld),
        .o_rdy   (w_mask_rdy),
        .i_data  (w_mask),
        .o_vld   (w_coord_vld),
        .i_rdy   (w_coord_rdy),
        .o_data  (w_coord)
    );

    // Address
    sqtc_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_vld   (w_coord_vld),
        .o_rdy   (w_coord_rdy),
        .i_data  (w_coord),
        .o_vld   (m_axis_tvalid),
        .i_rdy   (m_axis_tready),
        .o_data  (w_res)
    );

    // Pack the result
    assign m_axis_tdata = {7'd0, w_res.screen_y, w_res.screen_x,
                           w_res.src_address, w_res.drawn};

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the square thumbnail crop scaler. Thumbnail
// coordinates go in as stream transfers and registers are set over APB.
// A behavioural predictor works out the drawn flag, source address and
// screen position of every accepted coordinate. The predictor covers the
// centre crop, nearest-neighbour scaling, clamping and the corner rounding.
// Each result transfer is compared against the oldest prediction. Directed
// cases come first, then random settings and coordinates under four
// source and sink throttling mixes.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned MAX_TILE  = sqtc_pkg::MaxTileDefault;
    localparam int unsigned CUT_ROWS  = 10;
    localparam int unsigned ROW_TRIM [CUT_ROWS] = '{6, 4, 3, 2, 1, 1, 0, 0, 0, 0};
    localparam int unsigned SETTLE_CYCLES = 10;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: out_col[6:0], out_row[13:7], zero[15:14]
    logic [15:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: drawn[0], src_address[32:1], screen_x[44:33], screen_y[56:45],
    //        zero[63:57]
    logic [63:0] m_axis_tdata;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the register file
    logic [31:0] cfg_image_base = '0;
    logic [15:0] cfg_width      = '0;
    logic [15:0] cfg_height     = '0;
    logic [7:0]  cfg_tile       = 8'd88;
    logic [11:0] cfg_left       = '0;
    logic [11:0] cfg_top        = '0;

    sqtc_pkg::t_res pending_pixels [$];
    int unsigned    mismatch_count = 0;
    int unsigned    send_idle_pct  = 0;
    int unsigned    ready_stall_pct = 0;

    square_thumbnail_crop_scaler_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stop a hung run
    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Throttle the result side
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= ready_stall_pct);
    end

    // Work out the result of one thumbnail coordinate
    function automatic sqtc_pkg::t_res predict_pixel(input logic [6:0] col,
                                                    input logic [6:0] row);
        sqtc_pkg::t_res   res;
        int unsigned      size, cut, crop, sx0, sy0, sx, sy;
        longint unsigned  idx;
        size = (cfg_tile > MAX_TILE) ? MAX_TILE : cfg_tile;
        res = '0;
        res.screen_x = 12'(cfg_left + col);
        res.screen_y = 12'(cfg_top + row);
        if (cfg_width != 0 && cfg_height != 0 && size != 0 && col < size && row < size) begin
            // top rows win over bottom rows on short tiles
            if (row < CUT_ROWS) begin
                cut = ROW_TRIM[row];
            end else if (row + CUT_ROWS >= size) begin
                cut = ROW_TRIM[size - 1 - row];
            end else begin
                cut = 0;
            end
            if (2 * cut < size && col >= cut && col < size - cut) begin
                crop = cfg_width;
                sx0  = 0;
                sy0  = 0;
                if (cfg_width > cfg_height) begin
                    crop = cfg_height;
                    sx0  = (cfg_width - cfg_height) / 2;
                end else if (cfg_height > cfg_width) begin
                    sy0  = (cfg_height - cfg_width) / 2;
                end
                sy = sy0 + (row * crop) / size;
                if (sy >= cfg_height) sy = cfg_height - 1;
                sx = sx0 + (col * crop) / size;
                if (sx >= cfg_width) sx = cfg_width - 1;
                idx = longint'(sy) * cfg_width + sx;
                res.src_address = 32'(longint'(cfg_image_base) + 8 + 4 * idx);
                res.drawn = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Predict on each input transfer, compare on each result transfer
    always @(posedge i_clk) begin : pixel_monitor
        sqtc_pkg::t_res want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            pending_pixels.push_back(predict_pixel(s_axis_tdata[6:0], s_axis_tdata[13:7]));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: result with nothing pending, expected none actual %h",
                         $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("drawn", 32'(want.drawn), 32'(m_axis_tdata[0]));
                check_field("src_address", want.src_address, m_axis_tdata[32:1]);
                check_field("screen_x", 32'(want.screen_x), 32'(m_axis_tdata[44:33]));
                check_field("screen_y", 32'(want.screen_y), 32'(m_axis_tdata[56:45]));
            end
        end
    end

    // Send one coordinate, idling first at the current rate
    task automatic send_pixel(input int unsigned col, input int unsigned row);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, row[6:0], col[6:0]};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Hold off until every result is back and the pipeline is empty
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write: setup phase, access phase, then the bus goes idle
    task automatic write_register(input int unsigned index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(4 * index);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (index)
            sqtc_pkg::REG_IMAGE_BASE: cfg_image_base = value;
            sqtc_pkg::REG_SRC_WIDTH:  cfg_width      = value[15:0];
            sqtc_pkg::REG_SRC_HEIGHT: cfg_height     = value[15:0];
            sqtc_pkg::REG_TILE_EDGE:  cfg_tile       = value[7:0];
            sqtc_pkg::REG_DEST_LEFT:  cfg_left       = value[11:0];
            sqtc_pkg::REG_DEST_TOP:   cfg_top        = value[11:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [31:0] base, input int unsigned width,
                                  input int unsigned height, input int unsigned tile,
                                  input int unsigned left, input int unsigned top);
        write_register(sqtc_pkg::REG_IMAGE_BASE, base);
        write_register(sqtc_pkg::REG_SRC_WIDTH, width);
        write_register(sqtc_pkg::REG_SRC_HEIGHT, height);
        write_register(sqtc_pkg::REG_TILE_EDGE, tile);
        write_register(sqtc_pkg::REG_DEST_LEFT, left);
        write_register(sqtc_pkg::REG_DEST_TOP, top);
    endtask

    // Reset values: empty image draws nothing, positions still tracked
    task automatic test_reset_state();
        send_pixel(0, 0);
        send_pixel(127, 127);
        wait_drained();
    endtask

    // Full-size tile: corner cuts on top and bottom rows
    task automatic test_corner_rounding();
        write_settings(32'h0000_1000, 128, 128, 128, 0, 0);
        send_pixel(6, 0);
        send_pixel(5, 0);
        send_pixel(121, 0);
        send_pixel(122, 0);
        send_pixel(0, 10);
        send_pixel(127, 127);
        send_pixel(4, 126);
        wait_drained();
    endtask

    // Short tile on a tall image: top-row rule takes precedence
    task automatic test_short_tile();
        write_settings(32'h0000_2000, 30, 50, 12, 100, 200);
        send_pixel(6, 0);
        send_pixel(3, 2);
        send_pixel(8, 2);
        send_pixel(0, 9);
        send_pixel(0, 11);
        wait_drained();
    endtask

    // Zero, saturated and single-pixel tiles
    task automatic test_tile_extremes();
        write_settings(32'h0000_0100, 64, 64, 0, 0, 0);
        send_pixel(0, 0);
        wait_drained();
        write_register(sqtc_pkg::REG_TILE_EDGE, 255);
        send_pixel(127, 64);
        wait_drained();
        write_register(sqtc_pkg::REG_TILE_EDGE, 1);
        send_pixel(0, 0);
        wait_drained();
    endtask

    // Either dimension zero disables drawing
    task automatic test_empty_image();
        write_settings(32'h0000_0100, 0, 10, 20, 7, 9);
        send_pixel(10, 10);
        wait_drained();
        write_settings(32'h0000_0100, 10, 0, 20, 7, 9);
        send_pixel(10, 10);
        wait_drained();
    endtask

    // Wide crop, screen wrap and address wrap
    task automatic test_wraparound();
        write_settings(32'hFFFF_FFF0, 65535, 1, 128, 4095, 4095);
        send_pixel(64, 64);
        send_pixel(127, 64);
        wait_drained();
        write_settings(32'hFFFF_FFFF, 65535, 65535, 128, 4095, 4095);
        send_pixel(64, 64);
        wait_drained();
    endtask

    function automatic int unsigned random_dimension();
        int unsigned pick;
        pick = $urandom_range(19, 0);
        if (pick == 0) return 0;
        if (pick <= 3) return $urandom_range(65535, 1);
        return $urandom_range(400, 1);
    endfunction

    function automatic int unsigned random_tile();
        int unsigned pick;
        pick = $urandom_range(19, 0);
        if (pick == 0) return 0;
        if (pick == 1) return $urandom_range(255, 129);
        if (pick <= 5) return $urandom_range(19, 1);
        return $urandom_range(128, 20);
    endfunction

    // Random settings, coordinates mostly inside the tile
    task automatic test_random_phase(input int unsigned idle_pct,
                                     input int unsigned stall_pct);
        int unsigned size;
        send_idle_pct   = idle_pct;
        ready_stall_pct = stall_pct;
        repeat (5) begin
            write_settings($urandom(), random_dimension(), random_dimension(),
                           random_tile(), $urandom_range(4095, 0), $urandom_range(4095, 0));
            size = (cfg_tile > MAX_TILE) ? MAX_TILE : cfg_tile;
            repeat (90) begin
                if (size != 0 && $urandom_range(9, 0) < 8) begin
                    send_pixel($urandom_range(size - 1, 0), $urandom_range(size - 1, 0));
                end else begin
                    send_pixel($urandom_range(127, 0), $urandom_range(127, 0));
                end
            end
            wait_drained();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_corner_rounding();
        test_short_tile();
        test_tile_extremes();
        test_empty_image();
        test_wraparound();

        test_random_phase(0, 0);
        test_random_phase(81, 0);
        test_random_phase(0, 81);
        test_random_phase(33, 33);

        // Drop the source and let stragglers out
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_pixels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/sqtc_pkg.sv
rtl/core/sqtc_cfg.sv
rtl/core/sqtc_mask.sv
rtl/core/sqtc_scale.sv
rtl/core/sqtc_addr.sv
rtl/core/square_thumbnail_crop_scaler_unit.sv
tb/tb_top.sv
